// ===== rtl/pmsd_pkg.sv =====
// pmsd_pkg: shared constants, types and socket remap for the patch matrix scan block
// used by pmsd_front, pmsd_queue, pmsd_back and the top level
package pmsd_pkg;

    localparam int NUM_JACKS   = 32;
    localparam int CODE_BITS   = 8;
    localparam int SENSE_W     = 32;
    localparam int PHASE_W     = 3;
    localparam int SOCK_W      = 8;
    localparam int DEST_W      = 6;
    localparam int COUNT_W     = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int JACK_W     = (NUM_JACKS > 1) ? $clog2(NUM_JACKS) : 1;
    localparam int CODE_IDX_W = $clog2(CODE_BITS);
    localparam int PAD_W      = (NUM_JACKS > SENSE_W) ? NUM_JACKS : SENSE_W;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(CODE_BITS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_FIRE = 2'd2;
    localparam logic [SOCK_W-1:0]  DEST_BASE  = 8'd32;

    localparam logic KIND_CONNECT    = 1'b0;
    localparam logic KIND_DISCONNECT = 1'b1;

    typedef logic [NUM_JACKS-1:0][CODE_BITS-1:0] t_codes;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_back_state;

    // reverse the position within a group of eight
    function automatic logic [SOCK_W-1:0] f_remap(input logic [SOCK_W-1:0] s);
        return {s[SOCK_W-1:3], ~s[2:0]};
    endfunction

endpackage

// ===== rtl/pmsd_front.sv =====
// pmsd_front: takes scan phase beats and assembles one code per jack
// pushes each finished sweep into the queue; depends on pmsd_pkg
module pmsd_front import pmsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [SENSE_W-1:0] i_sense_bits,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_codes            o_push_codes
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    t_codes             r_asm, n_asm;
    logic [PAD_W-1:0]   sense_pad;
    logic               accept;
    logic               last_phase;

    assign sense_pad  = PAD_W'(i_sense_bits);
    assign last_phase = (r_phase == LAST_PHASE);
    assign o_stall    = last_phase && i_q_stat.full;
    assign accept     = i_valid && !o_stall;

    always_comb begin
        for (int j = 0; j < NUM_JACKS; j++) begin
            for (int b = 0; b < CODE_BITS; b++) begin
                if (r_phase[CODE_IDX_W-1:0] == CODE_IDX_W'(b)) begin
                    n_asm[j][b] = sense_pad[j];
                end else begin
                    n_asm[j][b] = r_asm[j][b];
                end
            end
        end
    end

    assign n_phase      = last_phase ? '0 : r_phase + PHASE_W'(1);
    assign o_push       = accept && last_phase;
    assign o_push_codes = n_asm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_asm   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_asm   <= n_asm;
        end
    end

endmodule

// ===== rtl/pmsd_queue.sv =====
// pmsd_queue: short register queue of finished sweeps between front and back
// depends on pmsd_pkg
module pmsd_queue import pmsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_codes  i_push_codes,
    input  logic    i_pop,
    output t_codes  o_head,
    output t_q_stat o_stat
);

    t_codes            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_codes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/pmsd_back.sv =====
// pmsd_back: debounces one sweep for all jacks, then emits the events one jack a cycle
// if unstalled; holds per-jack debounce stores, output register; depends on pmsd_pkg
module pmsd_back import pmsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_codes            i_head,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_event_kind,
    output logic [SOCK_W-1:0] o_source_socket,
    output logic [DEST_W-1:0] o_dest_socket,
    output logic              o_last_event
);

    t_back_state r_state, n_state;

    logic [CODE_BITS-1:0] r_prev  [NUM_JACKS];
    logic [COUNT_W-1:0]   r_count [NUM_JACKS];
    logic [CODE_BITS-1:0] r_acc   [NUM_JACKS];
    logic                 r_ev_kind [NUM_JACKS];
    logic [SOCK_W-1:0]    r_ev_src  [NUM_JACKS];

    logic [COUNT_W-1:0]   n_count  [NUM_JACKS];
    logic                 fire     [NUM_JACKS];
    logic                 ev_kind  [NUM_JACKS];
    logic [SOCK_W-1:0]    ev_src   [NUM_JACKS];
    logic [NUM_JACKS-1:0] ev_mask;

    logic [NUM_JACKS-1:0] r_mask, mask_rest;
    logic [JACK_W-1:0]    r_idx;
    logic                 r_o_valid;
    logic                 o_load, step, last_ev;
    logic [SOCK_W-1:0]    dest_full;

    // debounce every jack of the head sweep at once
    always_comb begin
        for (int j = 0; j < NUM_JACKS; j++) begin
            logic [SOCK_W-1:0] code_w, acc_w;
            code_w = SOCK_W'(i_head[j]);
            acc_w  = SOCK_W'(r_acc[j]);
            if (i_head[j] != r_prev[j]) begin
                n_count[j] = '0;
            end else if (r_count[j] != COUNT_MAX) begin
                n_count[j] = r_count[j] + COUNT_W'(1);
            end else begin
                n_count[j] = r_count[j];
            end
            fire[j] = (n_count[j] == COUNT_FIRE);
            if (code_w != '0) begin
                ev_kind[j] = KIND_CONNECT;
                ev_src[j]  = f_remap(code_w - SOCK_W'(1));
                ev_mask[j] = fire[j];
            end else begin
                ev_kind[j] = KIND_DISCONNECT;
                ev_src[j]  = f_remap(acc_w - SOCK_W'(1));
                ev_mask[j] = fire[j] && (acc_w != '0);
            end
        end
    end

    assign mask_rest = r_mask & ~(NUM_JACKS'(1) << r_idx);
    assign last_ev   = (mask_rest == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && (ev_mask != '0)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_load && last_ev) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop  = 1'b0;
        o_load = 1'b0;
        step   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = !i_q_stat.empty;
            end
            S_EMIT: begin
                o_load = r_mask[r_idx] && (!r_o_valid || !i_stall);
                step   = !r_mask[r_idx] || o_load;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_idx   <= '0;
            for (int j = 0; j < NUM_JACKS; j++) begin
                r_prev[j]  <= '0;
                r_count[j] <= '0;
                r_acc[j]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_mask <= ev_mask;
                r_idx  <= '0;
                for (int j = 0; j < NUM_JACKS; j++) begin
                    r_prev[j]  <= i_head[j];
                    r_count[j] <= n_count[j];
                    if (fire[j]) begin
                        r_acc[j] <= i_head[j];
                    end
                end
            end else begin
                if (o_load) begin
                    r_mask <= mask_rest;
                end
                if (step && (r_idx != JACK_W'(NUM_JACKS - 1))) begin
                    r_idx <= r_idx + JACK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < NUM_JACKS; j++) begin
                r_ev_kind[j] <= ev_kind[j];
                r_ev_src[j]  <= ev_src[j];
            end
        end
    end

    assign dest_full = f_remap(DEST_BASE + SOCK_W'(r_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_event_kind    <= r_ev_kind[r_idx];
            o_source_socket <= r_ev_src[r_idx];
            o_dest_socket   <= dest_full[DEST_W-1:0];
            o_last_event    <= last_ev;
        end
    end

    assign o_valid = r_o_valid;

    // no pending events while waiting for a sweep
    a_idle_mask_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_mask == '0))
        else $error("pending events while idle");

    // a sweep with events always enters emission
    a_pop_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (ev_mask != '0)) |=> (r_state == S_EMIT))
        else $error("sweep with events not emitted");

    // the beat flagged last leaves nothing behind
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && last_ev) |=> ((r_mask == '0) && (r_state == S_IDLE)))
        else $error("events left after last beat");

    // a new beat is never loaded over an unaccepted one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> (!r_o_valid || !i_stall))
        else $error("output beat overwritten");

endmodule

// ===== rtl/patch_matrix_scan_debounce_unit.sv =====
// patch_matrix_scan_debounce_unit: top level of the patch matrix scan and debounce block
// joins pmsd_front, pmsd_queue and pmsd_back; depends on pmsd_pkg
//
//  channel   dir   handshake           payload
//  scan      in    i_valid / o_stall   i_sense_bits
//  event     out   o_valid / i_stall   o_event_kind, o_source_socket, o_dest_socket,
//                                      o_last_event
//
// phases 0..6 are taken one a cycle; phase 7 goes to a two-sweep queue
// the back end debounces all jacks of a sweep at once as it pops it, then walks the
// jacks one a cycle until the last event, halting at a jack with an event while stalled
// the scan side stalls only on phase 7 while the queue holds two sweeps
// event stalls hold the output register; reset clears all debounce stores at once
module patch_matrix_scan_debounce_unit import pmsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [SENSE_W-1:0] i_sense_bits,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_event_kind,
    output logic [SOCK_W-1:0]  o_source_socket,
    output logic [DEST_W-1:0]  o_dest_socket,
    output logic               o_last_event
);

    t_q_stat q_stat;
    logic    push, pop;
    t_codes  push_codes, head;

    pmsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sense_bits (i_sense_bits),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_codes (push_codes)
    );

    pmsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_codes (push_codes),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (q_stat)
    );

    pmsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_source_socket (o_source_socket),
        .o_dest_socket   (o_dest_socket),
        .o_last_event    (o_last_event)
    );

endmodule
